### hw/rtl/delay_sorted_block_queue_defines.svh
// ---------------------------------------------------------------------------
// Delay sorted block queue assertion macros
// Shared concurrent assertion forms for the queue checker.
// ---------------------------------------------------------------------------
`ifndef DELAY_SORTED_BLOCK_QUEUE_DEFINES_SVH
`define DELAY_SORTED_BLOCK_QUEUE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DSBQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue check failed");

// next-cycle implication, disabled in reset
`define DSBQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue check failed");

`endif

### hw/rtl/dsbq_pkg.sv
// ---------------------------------------------------------------------------
// Delay sorted block queue package
// Opcodes, status codes, controller states and the cell control bundle.
// ---------------------------------------------------------------------------
package dsbq_pkg;

   localparam int OPCODE_BITS = 2;
   localparam int HANDLE_BITS = 5;
   localparam int DELAY_BITS  = 32;
   localparam int COUNT_BITS  = 6;
   localparam int STATUS_BITS = 2;

   localparam logic [OPCODE_BITS-1:0] OP_APPEND = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_INSERT = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_POP    = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic {
      S_IDLE,
      S_APPLY
   } dsbq_state_type;

   typedef struct packed {
      logic load;
      logic insert;
      logic apply;
      logic pop;
      logic push;
   } cell_ctrl_type;

endpackage

### hw/rtl/dsbq_cell.sv
// ---------------------------------------------------------------------------
// Delay sorted block queue cell
// One queue slot: holds a key and handle, flags itself as the insertion
// point candidate and shifts toward the head or the tail with its neighbors.
// ---------------------------------------------------------------------------
module dsbq_cell #(
   parameter int KEY_BITS = 32
) (
   input  logic                            clock,
   input  dsbq_pkg::cell_ctrl_type         ctrl,
   input  logic                            occupied,
   input  logic [KEY_BITS-1:0]             cmp_key,
   input  logic [KEY_BITS-1:0]             new_key,
   input  logic [dsbq_pkg::HANDLE_BITS-1:0] new_handle,
   input  logic [KEY_BITS-1:0]             left_key,
   input  logic [dsbq_pkg::HANDLE_BITS-1:0] left_handle,
   input  logic [KEY_BITS-1:0]             right_key,
   input  logic [dsbq_pkg::HANDLE_BITS-1:0] right_handle,
   input  logic                            seen_in,
   output logic [KEY_BITS-1:0]             key,
   output logic [dsbq_pkg::HANDLE_BITS-1:0] handle,
   output logic                            seen_out
);
   import dsbq_pkg::*;

   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic                   cond_ff, cond_in;

   assign cond_in  = !occupied || (ctrl.insert && (key_ff > cmp_key));
   assign seen_out = seen_in || cond_ff;
   assign key      = key_ff;
   assign handle   = handle_ff;

   always_comb begin
      key_in    = key_ff;
      handle_in = handle_ff;
      if (ctrl.apply && ctrl.pop) begin
         key_in    = right_key;
         handle_in = right_handle;
      end else if (ctrl.apply && ctrl.push) begin
         if (seen_in) begin
            key_in    = left_key;
            handle_in = left_handle;
         end else if (cond_ff) begin
            key_in    = new_key;
            handle_in = new_handle;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      handle_ff <= handle_in;
      if (ctrl.load) begin
         cond_ff <= cond_in;
      end
   end

endmodule

### hw/rtl/delay_sorted_block_queue.sv
// ---------------------------------------------------------------------------
// Delay sorted block queue
// Bounded queue of block handles with delay keys: append, stable sorted
// insert and pop head, built as a row of shifting cells.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// while S_APPLY applies the request, so no new request is taken until it is
// done. The result appears on the rsp_ ports with rsp_strobe for exactly one
// cycle, out of the response registers loaded in S_APPLY, and is taken at the
// edge that ends the strobe. The receiver cannot stall: a result is never held
// back, and the edge that takes it can already accept the next request.
// Inside the cell row: at the accepting edge every cell
// registers whether it is the insertion point (on an insert a key strictly
// greater, or empty); in the next cycle the insertion point ripples down the
// chain and all cells shift at once. No clearing pass follows reset.
module delay_sorted_block_queue #(
   parameter int CAPACITY = 32,
   parameter int KEY_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [dsbq_pkg::OPCODE_BITS-1:0] req_opcode,
   input  logic [dsbq_pkg::HANDLE_BITS-1:0] req_block_id,
   input  logic [dsbq_pkg::DELAY_BITS-1:0]  req_delay_key,
   output logic                             rsp_strobe,
   output logic                             rsp_popped_valid,
   output logic [dsbq_pkg::HANDLE_BITS-1:0] rsp_popped_block,
   output logic [dsbq_pkg::DELAY_BITS-1:0]  rsp_popped_delay,
   output logic [dsbq_pkg::COUNT_BITS-1:0]  rsp_entry_count,
   output logic [dsbq_pkg::STATUS_BITS-1:0] rsp_status
);
   import dsbq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   dsbq_state_type state_ff, state_in;
   cell_ctrl_type  ctrl;

   logic [CW-1:0]          count_ff, count_in;
   logic [OPCODE_BITS-1:0] op_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic                   accept, full, empty;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_BITS-1:0] rsp_block_ff, rsp_block_in;
   logic [DELAY_BITS-1:0]  rsp_delay_ff, rsp_delay_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   logic [KEY_BITS-1:0]    cell_key    [CAPACITY];
   logic [HANDLE_BITS-1:0] cell_handle [CAPACITY];
   logic [CAPACITY:0]      seen;

   assign accept = start && !busy;
   assign full   = (count_ff == CW'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign seen[0] = 1'b0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs and result
   always_comb begin
      busy          = (state_ff == S_APPLY);
      ctrl.load     = start && (state_ff == S_IDLE);
      ctrl.insert   = (req_opcode == OP_INSERT);
      ctrl.apply    = (state_ff == S_APPLY);
      ctrl.pop      = 1'b0;
      ctrl.push     = 1'b0;
      count_in      = count_ff;
      rsp_strobe_in = (state_ff == S_APPLY);
      rsp_valid_in  = 1'b0;
      rsp_block_in  = '0;
      rsp_delay_in  = '0;
      rsp_status_in = STATUS_OK;
      unique case (op_ff) inside
         OP_APPEND, OP_INSERT: begin
            if (full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               ctrl.push = 1'b1;
               count_in  = count_ff + CW'(1);
            end
         end
         OP_POP: begin
            if (empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               ctrl.pop     = 1'b1;
               count_in     = count_ff - CW'(1);
               rsp_valid_in = 1'b1;
               rsp_block_in = cell_handle[0];
               rsp_delay_in = DELAY_BITS'(cell_key[0]);
            end
         end
         default: begin
         end
      endcase
      if (state_ff != S_APPLY) begin
         count_in = count_ff;
      end
      rsp_count_in = COUNT_BITS'(count_in);
   end

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic [KEY_BITS-1:0]    lkey, rkey;
         logic [HANDLE_BITS-1:0] lhandle, rhandle;
         if (i == 0) begin : g_head
            assign lkey    = cell_key[i];
            assign lhandle = cell_handle[i];
         end else begin : g_mid
            assign lkey    = cell_key[i-1];
            assign lhandle = cell_handle[i-1];
         end
         if (i == CAPACITY - 1) begin : g_tail
            assign rkey    = cell_key[i];
            assign rhandle = cell_handle[i];
         end else begin : g_body
            assign rkey    = cell_key[i+1];
            assign rhandle = cell_handle[i+1];
         end
         dsbq_cell #(
            .KEY_BITS(KEY_BITS)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (count_ff > CW'(i)),
            .cmp_key     (KEY_BITS'(req_delay_key)),
            .new_key     (key_ff),
            .new_handle  (handle_ff),
            .left_key    (lkey),
            .left_handle (lhandle),
            .right_key   (rkey),
            .right_handle(rhandle),
            .seen_in     (seen[i]),
            .key         (cell_key[i]),
            .handle      (cell_handle[i]),
            .seen_out    (seen[i+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_opcode;
         handle_ff <= req_block_id;
         key_ff    <= KEY_BITS'(req_delay_key);
      end
      if (state_ff == S_APPLY) begin
         rsp_valid_ff  <= rsp_valid_in;
         rsp_block_ff  <= rsp_block_in;
         rsp_delay_ff  <= rsp_delay_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_popped_valid = rsp_valid_ff;
   assign rsp_popped_block = rsp_block_ff;
   assign rsp_popped_delay = rsp_delay_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

### hw/rtl/dsbq_checker.sv
// ---------------------------------------------------------------------------
// Delay sorted block queue checker
// Port-level timing and result consistency checks, bound to the top level.
// ---------------------------------------------------------------------------
`include "delay_sorted_block_queue_defines.svh"

module dsbq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_strobe,
   input logic                             rsp_popped_valid,
   input logic [dsbq_pkg::COUNT_BITS-1:0]  rsp_entry_count,
   input logic [dsbq_pkg::STATUS_BITS-1:0] rsp_status
);
   import dsbq_pkg::*;

   logic accept;

   assign accept = start && !busy;

   `DSBQ_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_strobe)
   `DSBQ_ASSERT_NEXT(a_accept_result, clock, reset, busy, rsp_strobe && !busy)
   `DSBQ_ASSERT_NOW(a_pop_ok, clock, reset, rsp_strobe && rsp_popped_valid,
                    rsp_status == STATUS_OK)
   `DSBQ_ASSERT_NOW(a_empty_count, clock, reset, rsp_strobe && rsp_status == STATUS_EMPTY,
                    rsp_entry_count == '0 && !rsp_popped_valid)

endmodule

bind delay_sorted_block_queue dsbq_checker u_dsbq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_popped_valid(rsp_popped_valid),
   .rsp_entry_count (rsp_entry_count),
   .rsp_status      (rsp_status)
);

### tb/delay_sorted_block_queue_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Delay sorted block queue testbench
// Drives append, sorted insert, pop and the unused opcode through the
// start/busy port and keeps a shadow queue of handle/key pairs. The shadow
// queue gives the expected response of every accepted request, and each
// strobed response is checked field by field against the oldest one. The run
// covers the empty and full cases, equal-key ordering and key extremes, then
// random traffic with push-heavy and pop-heavy stretches under three
// sender idle rates.
// ---------------------------------------------------------------------------
module delay_sorted_block_queue_tb;
   import dsbq_pkg::*;

   localparam int DEPTH = 32;
   localparam int STALL_LIMIT = 4000;
   localparam logic [OPCODE_BITS-1:0] OP_NOP = 2'd3;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [DELAY_BITS-1:0]  key;
   } slot_type;

   typedef struct packed {
      logic                   valid;
      logic [HANDLE_BITS-1:0] block;
      logic [DELAY_BITS-1:0]  delay;
      logic [COUNT_BITS-1:0]  count;
      logic [STATUS_BITS-1:0] status;
   } outcome_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [OPCODE_BITS-1:0] req_opcode = OP_APPEND;
   logic [HANDLE_BITS-1:0] req_block_id = '0;
   logic [DELAY_BITS-1:0]  req_delay_key = '0;
   logic                   rsp_strobe;
   logic                   rsp_popped_valid;
   logic [HANDLE_BITS-1:0] rsp_popped_block;
   logic [DELAY_BITS-1:0]  rsp_popped_delay;
   logic [COUNT_BITS-1:0]  rsp_entry_count;
   logic [STATUS_BITS-1:0] rsp_status;

   slot_type    shadow_queue[$];
   outcome_type pending_outcomes[$];
   int          mismatch_count = 0;
   int          gap_pct = 0;
   int          quiet_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   delay_sorted_block_queue #(
      .CAPACITY(DEPTH),
      .KEY_BITS(DELAY_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_block_id     (req_block_id),
      .req_delay_key    (req_delay_key),
      .rsp_strobe       (rsp_strobe),
      .rsp_popped_valid (rsp_popped_valid),
      .rsp_popped_block (rsp_popped_block),
      .rsp_popped_delay (rsp_popped_delay),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_status       (rsp_status)
   );

   function automatic outcome_type queue_outcome(input logic [OPCODE_BITS-1:0] op,
                                                 input logic [HANDLE_BITS-1:0] id,
                                                 input logic [DELAY_BITS-1:0]  key);
      outcome_type res;
      slot_type    entry;
      int          pos;
      int          i;
      res = '0;
      entry.handle = id;
      entry.key = key;
      case (op)
         OP_APPEND, OP_INSERT: begin
            if (shadow_queue.size() >= DEPTH) begin
               res.status = STATUS_FULL;
            end else if (op == OP_APPEND) begin
               shadow_queue.push_back(entry);
            end else begin
               // first strictly greater key wins, so equal keys keep arrival order
               pos = shadow_queue.size();
               for (i = shadow_queue.size() - 1; i >= 0; i--) begin
                  if (shadow_queue[i].key > key) pos = i;
               end
               shadow_queue.insert(pos, entry);
            end
         end
         OP_POP: begin
            if (shadow_queue.size() == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               entry = shadow_queue.pop_front();
               res.valid = 1'b1;
               res.block = entry.handle;
               res.delay = entry.key;
            end
         end
         default: ;
      endcase
      res.count = COUNT_BITS'(shadow_queue.size());
      return res;
   endfunction

   function automatic logic [DELAY_BITS-1:0] random_key();
      case ($urandom_range(3))
         0: return DELAY_BITS'($urandom_range(15));
         1: return $urandom;
         2: return $urandom_range(1) ? '1 : '0;
         default: return 32'h8000_0000 ^ DELAY_BITS'($urandom_range(3));
      endcase
   endfunction

   task automatic flag_mismatch(input string msg);
      if (mismatch_count < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            got.valid = rsp_popped_valid;
            got.block = rsp_popped_block;
            got.delay = rsp_popped_delay;
            got.count = rsp_entry_count;
            got.status = rsp_status;
            if (pending_outcomes.size() == 0) begin
               flag_mismatch($sformatf("response with none expected: valid=%0d block=%0d %s",
                  got.valid, got.block, $sformatf("delay=%h count=%0d status=%0d",
                  got.delay, got.count, got.status)));
            end else begin
               want = pending_outcomes.pop_front();
               if (got.valid !== want.valid || got.block !== want.block ||
                   got.delay !== want.delay || got.count !== want.count ||
                   got.status !== want.status) begin
                  flag_mismatch($sformatf(
                     "expected valid=%0d block=%0d delay=%h count=%0d status=%0d, %s",
                     want.valid, want.block, want.delay, want.count, want.status,
                     $sformatf("got valid=%0d block=%0d delay=%h count=%0d status=%0d",
                        got.valid, got.block, got.delay, got.count, got.status)));
               end
            end
         end
         if (start && busy === 1'b0) begin
            pending_outcomes.push_back(queue_outcome(req_opcode, req_block_id,
                                                     req_delay_key));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe === 1'b1 || (start && busy === 1'b0)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_request(input logic [OPCODE_BITS-1:0] op,
                               input logic [HANDLE_BITS-1:0] id,
                               input logic [DELAY_BITS-1:0]  key);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_opcode <= op;
      req_block_id <= id;
      req_delay_key <= key;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic test_directed();
      send_request(OP_POP, 5'd31, 32'hFFFF_FFFF);
      send_request(OP_NOP, 5'd0, 32'h0);
      send_request(OP_APPEND, 5'd31, 32'hFFFF_FFFF);
      send_request(OP_APPEND, 5'd0, 32'h0);
      send_request(OP_INSERT, 5'd5, 32'd100);
      send_request(OP_INSERT, 5'd7, 32'd100);
      send_request(OP_INSERT, 5'd9, 32'h0);
      send_request(OP_INSERT, 5'd10, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 5'd21, 32'hAAAA_AAAA);
      send_request(OP_APPEND, 5'd10, 32'h5555_5555);
      send_request(OP_NOP, 5'd31, 32'hFFFF_FFFF);
      // drain all eight, then one more on empty
      repeat (9) send_request(OP_POP, 5'($urandom_range(31)), $urandom);
   endtask

   task automatic test_full_queue();
      repeat (DEPTH) send_request(OP_INSERT, 5'($urandom_range(31)),
                                  DELAY_BITS'($urandom_range(7)));
      send_request(OP_APPEND, 5'd31, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 5'd1, 32'h0);
      send_request(OP_NOP, 5'd2, 32'h3);
      send_request(OP_POP, 5'd0, 32'h0);
      send_request(OP_INSERT, 5'd17, 32'h0);
      send_request(OP_APPEND, 5'd18, 32'h1);
      repeat (DEPTH + 1) send_request(OP_POP, 5'($urandom_range(31)), $urandom);
   endtask

   task automatic test_random(input int count);
      int                     push_pct;
      int                     i;
      logic [OPCODE_BITS-1:0] op;
      push_pct = 50;
      for (i = 0; i < count; i++) begin
         // pick fill-heavy, balanced or drain-heavy stretches at random to visit full and empty
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 15;
               1: push_pct = 50;
               default: push_pct = 85;
            endcase
         end
         if ($urandom_range(99) < 3) op = OP_NOP;
         else if ($urandom_range(99) < push_pct)
            op = ($urandom_range(99) < 60) ? OP_INSERT : OP_APPEND;
         else op = OP_POP;
         send_request(op, 5'($urandom_range(31)), random_key());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 32;
      test_directed();
      test_full_queue();
      test_random(620);
      gap_pct = 85;
      test_random(580);
      gap_pct = 0;
      test_random(620);
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/dsbq_pkg.sv
hw/rtl/dsbq_cell.sv
hw/rtl/delay_sorted_block_queue.sv
hw/rtl/dsbq_checker.sv
tb/delay_sorted_block_queue_tb.sv
